// ----- sv/assert_macros.svh -----
// Assertion macros shared by the binary extended gcd block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/bgcd_pkg.sv -----
// Package with widths, op codes, structs and helpers for the binary extended gcd block
package bgcd_pkg;

    localparam int OPERAND_WIDTH = 64;
    localparam int FIELD_W       = 64;
    localparam int SH_W          = $clog2(OPERAND_WIDTH);
    localparam int CNT_W         = $clog2(2 * OPERAND_WIDTH);

    typedef logic [OPERAND_WIDTH-1:0] t_word;
    typedef logic [3:0]               t_op;

    localparam t_op OP_HOLD  = 4'd0;
    localparam t_op OP_LOAD  = 4'd1;
    localparam t_op OP_ZERO  = 4'd2;
    localparam t_op OP_ALIGN = 4'd3;
    localparam t_op OP_SHX   = 4'd4;
    localparam t_op OP_SHY   = 4'd5;
    localparam t_op OP_SUBX  = 4'd6;
    localparam t_op OP_SUBY  = 4'd7;
    localparam t_op OP_SUM   = 4'd8;
    localparam t_op OP_HALF  = 4'd9;
    localparam t_op OP_HALVE = 4'd10;
    localparam t_op OP_DIFF  = 4'd11;
    localparam t_op OP_FIX   = 4'd12;

    typedef struct packed {
        t_op  op;
        logic ready;
        logic finish;
    } t_ctrl;

    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic x_odd;
        logic y_odd;
        logic x_eq_y;
        logic x_gt_y;
        logic acc_zero;
    } t_stat;

    typedef struct packed {
        t_word gcd;
        t_word ucoef;
        t_word vcoef;
    } t_result;

    function automatic logic [FIELD_W-1:0] sext_field(input t_word v);
        logic [FIELD_W-1:0] r;
        r = {FIELD_W{v[OPERAND_WIDTH-1]}};
        r[OPERAND_WIDTH-1:0] = v;
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] zext_field(input t_word v);
        logic [FIELD_W-1:0] r;
        r = '0;
        r[OPERAND_WIDTH-1:0] = v;
        return r;
    endfunction

endpackage

// ----- sv/bgcd_if.sv -----
// Valid/ready channel interfaces for operand and result items
interface bgcd_in_if import bgcd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] first_operand;
    logic [FIELD_W-1:0] second_operand;

    modport source (output valid, output first_operand, output second_operand, input ready);
    modport sink   (input valid, input first_operand, input second_operand, output ready);
endinterface

interface bgcd_out_if import bgcd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic        [FIELD_W-1:0] gcd_value;
    logic signed [FIELD_W-1:0] u_coefficient;
    logic signed [FIELD_W-1:0] v_coefficient;

    modport source (output valid, output gcd_value, output u_coefficient,
                    output v_coefficient, input ready);
    modport sink   (input valid, input gcd_value, input u_coefficient,
                    input v_coefficient, output ready);
endinterface

// ----- sv/bgcd_ctrl.sv -----
// Sequencer that steps the shared gcd datapath through its phases
module bgcd_ctrl import bgcd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_ALIGN  = 4'd2;
    localparam logic [3:0] S_LOOP   = 4'd3;
    localparam logic [3:0] S_SUM    = 4'd4;
    localparam logic [3:0] S_HALF   = 4'd5;
    localparam logic [3:0] S_HALVE  = 4'd6;
    localparam logic [3:0] S_DIFF   = 4'd7;
    localparam logic [3:0] S_FIX    = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state       = r_state;
        o_ctrl.op     = OP_HOLD;
        o_ctrl.ready  = 1'b0;
        o_ctrl.finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ctrl.ready = 1'b1;
                if (i_start) begin
                    o_ctrl.op = OP_LOAD;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.x_zero || i_stat.y_zero) begin
                    o_ctrl.op = OP_ZERO;
                    n_state   = S_FINISH;
                end else begin
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                if (!i_stat.x_odd && !i_stat.y_odd) begin
                    o_ctrl.op = OP_ALIGN;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (!i_stat.x_odd) begin
                    o_ctrl.op = OP_SHX;
                end else if (!i_stat.y_odd) begin
                    o_ctrl.op = OP_SHY;
                end else if (i_stat.x_eq_y) begin
                    n_state = S_SUM;
                end else if (i_stat.x_gt_y) begin
                    o_ctrl.op = OP_SUBX;
                end else begin
                    o_ctrl.op = OP_SUBY;
                end
            end
            S_SUM: begin
                o_ctrl.op = OP_SUM;
                n_state   = S_HALF;
            end
            S_HALF: begin
                o_ctrl.op = OP_HALF;
                n_state   = S_HALVE;
            end
            S_HALVE: begin
                if (i_stat.acc_zero) begin
                    n_state = S_DIFF;
                end else begin
                    o_ctrl.op = OP_HALVE;
                end
            end
            S_DIFF: begin
                o_ctrl.op = OP_DIFF;
                n_state   = S_FIX;
            end
            S_FIX: begin
                o_ctrl.op = OP_FIX;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (i_out_free) begin
                    o_ctrl.finish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/bgcd_datapath.sv -----
// Shared subtract, shift and add unit with the operand and cofactor registers
`include "assert_macros.svh"
module bgcd_datapath import bgcd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ctrl   i_ctrl,
    input  t_word   i_first_operand,
    input  t_word   i_second_operand,
    output t_stat   o_stat,
    output t_result o_result
);

    t_word            r_x,   n_x;
    t_word            r_y,   n_y;
    t_word            r_pu0, n_pu0;
    t_word            r_pu1, n_pu1;
    t_word            r_pv0, n_pv0;
    t_word            r_pv1, n_pv1;
    t_word            r_du,  n_du;
    t_word            r_dv,  n_dv;
    t_word            r_hu,  n_hu;
    t_word            r_hv,  n_hv;
    logic [SH_W-1:0]  r_common, n_common;
    logic [CNT_W-1:0] r_acc,    n_acc;

    t_word diff_xy;
    t_word diff_yx;
    logic  odd_mask;

    assign diff_xy  = r_x - r_y;
    assign diff_yx  = r_y - r_x;
    assign odd_mask = r_pv0[0] | r_pu0[0];

    assign o_stat.x_zero   = (r_x == '0);
    assign o_stat.y_zero   = (r_y == '0);
    assign o_stat.x_odd    = r_x[0];
    assign o_stat.y_odd    = r_y[0];
    assign o_stat.x_eq_y   = (r_x == r_y);
    assign o_stat.x_gt_y   = (r_x > r_y);
    assign o_stat.acc_zero = (r_acc == '0);

    assign o_result.gcd   = r_y << r_common;
    assign o_result.ucoef = r_pv0;
    assign o_result.vcoef = '0 - r_pu0;

    always_comb begin
        n_x      = r_x;
        n_y      = r_y;
        n_pu0    = r_pu0;
        n_pu1    = r_pu1;
        n_pv0    = r_pv0;
        n_pv1    = r_pv1;
        n_du     = r_du;
        n_dv     = r_dv;
        n_hu     = r_hu;
        n_hv     = r_hv;
        n_common = r_common;
        n_acc    = r_acc;
        case (i_ctrl.op)
            OP_HOLD: begin
            end
            OP_LOAD: begin
                n_x      = i_first_operand;
                n_y      = i_second_operand;
                n_pv0    = t_word'(1);
                n_pu0    = '0;
                n_pv1    = '0;
                n_pu1    = t_word'(1);
                n_common = '0;
                n_acc    = '0;
            end
            OP_ZERO: begin
                if (r_x == '0) begin
                    n_pv0 = '0;
                    n_pu0 = (r_y == '0) ? '0 : '1;
                end else begin
                    n_y   = r_x;
                    n_pv0 = t_word'(1);
                    n_pu0 = '0;
                end
            end
            OP_ALIGN: begin
                n_x      = r_x >> 1;
                n_y      = r_y >> 1;
                n_common = r_common + SH_W'(1);
            end
            OP_SHX: begin
                n_x   = r_x >> 1;
                n_pu1 = r_pu1 << 1;
                n_pv1 = r_pv1 << 1;
                n_acc = r_acc + CNT_W'(1);
            end
            OP_SHY: begin
                n_y   = r_y >> 1;
                n_pu0 = r_pu0 << 1;
                n_pv0 = r_pv0 << 1;
                n_acc = r_acc + CNT_W'(1);
            end
            OP_SUBX: begin
                n_x   = diff_xy >> 1;
                n_pu0 = r_pu0 + r_pu1;
                n_pv0 = r_pv0 + r_pv1;
                n_pu1 = r_pu1 << 1;
                n_pv1 = r_pv1 << 1;
                n_acc = r_acc + CNT_W'(1);
            end
            OP_SUBY: begin
                n_y   = diff_yx >> 1;
                n_pu1 = r_pu1 + r_pu0;
                n_pv1 = r_pv1 + r_pv0;
                n_pu0 = r_pu0 << 1;
                n_pv0 = r_pv0 << 1;
                n_acc = r_acc + CNT_W'(1);
            end
            OP_SUM: begin
                n_du = r_pu0 + r_pu1;
                n_dv = r_pv0 + r_pv1;
            end
            OP_HALF: begin
                n_hu = (r_du >> 1) + t_word'(r_du[0]);
                n_hv = (r_dv >> 1) + t_word'(r_dv[0]);
            end
            OP_HALVE: begin
                n_pv0 = (r_pv0 >> 1) + (odd_mask ? r_hv : '0);
                n_pu0 = (r_pu0 >> 1) + (odd_mask ? r_hu : '0);
                n_acc = r_acc - CNT_W'(1);
            end
            OP_DIFF: begin
                n_pv1 = r_dv - r_pv0;
            end
            OP_FIX: begin
                if (r_pv0 > r_pv1) begin
                    n_pv0 = r_pv0 - r_dv;
                    n_pu0 = r_pu0 - r_du;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_y      <= n_y;
        r_pu0    <= n_pu0;
        r_pu1    <= n_pu1;
        r_pv0    <= n_pv0;
        r_pv1    <= n_pv1;
        r_du     <= n_du;
        r_dv     <= n_dv;
        r_hu     <= n_hu;
        r_hv     <= n_hv;
        r_common <= n_common;
        r_acc    <= n_acc;
    end

    `ASSERT_SAME(a_subx_odd_ordered, i_clk, i_rst_n, i_ctrl.op == OP_SUBX, r_x[0] && r_y[0] && (r_x > r_y))
    `ASSERT_SAME(a_shx_nonzero, i_clk, i_rst_n, i_ctrl.op == OP_SHX, r_x != '0)
    `ASSERT_SAME(a_halve_count, i_clk, i_rst_n, i_ctrl.op == OP_HALVE, r_acc != '0)

endmodule

// ----- sv/binary_extended_gcd_top.sv -----
// Binary extended gcd block: operand channel in, gcd and Bezout coefficients out
//
// Usage: present first_operand and second_operand on i_req; the item is taken when
// valid and ready are both high. Ready is high only while the block is idle and out of
// reset, so one item is in work at a time. The result item (gcd_value, u_coefficient,
// v_coefficient, with gcd = u*u_coefficient + v*v_coefficient modulo 2^64) appears on
// o_rsp from an output register and stays until o_rsp.ready takes it.
// The shared subtract/shift unit does one subtraction or one single-bit shift per cycle,
// and the halving pass does one step per single-bit shift accumulated in the reduction
// loop, of which there are at most 2*63.
// A stalled receiver holds the result in the output register; the next item is still
// taken and worked on, and only its final hand-over waits for the register to free.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and empties the output
// register; the block is ready again as soon as reset is released.
`include "assert_macros.svh"
module binary_extended_gcd_top import bgcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bgcd_in_if.sink    i_req,
    bgcd_out_if.source o_rsp
);

    t_ctrl   w_ctrl;
    t_stat   w_stat;
    t_result w_result;
    logic    w_out_free;

    logic                      r_out_valid;
    logic        [FIELD_W-1:0] r_gcd;
    logic signed [FIELD_W-1:0] r_ucoef;
    logic signed [FIELD_W-1:0] r_vcoef;

    assign w_out_free = !r_out_valid || o_rsp.ready;

    bgcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_req.valid),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    bgcd_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (w_ctrl),
        .i_first_operand  (i_req.first_operand[OPERAND_WIDTH-1:0]),
        .i_second_operand (i_req.second_operand[OPERAND_WIDTH-1:0]),
        .o_stat           (w_stat),
        .o_result         (w_result)
    );

    assign i_req.ready         = w_ctrl.ready && i_rst_n;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.gcd_value     = r_gcd;
    assign o_rsp.u_coefficient = r_ucoef;
    assign o_rsp.v_coefficient = r_vcoef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.finish) begin
            r_gcd   <= zext_field(w_result.gcd);
            r_ucoef <= sext_field(w_result.ucoef);
            r_vcoef <= sext_field(w_result.vcoef);
        end
    end

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    `ASSERT_SAME(a_finish_into_free, i_clk, i_rst_n, w_ctrl.finish, !r_out_valid || o_rsp.ready)

endmodule

// ----- verif/tb_binary_extended_gcd_top.sv -----
// Self-checking testbench for the binary extended gcd block: directed table, then random operands
`timescale 1ns / 100ps
module tb_binary_extended_gcd_top;
    import bgcd_pkg::*;

    localparam int                 NUM_DIRECTED   = 24;
    localparam int                 RANDOM_ITEMS   = 800;
    localparam int                 BACKLOG_AT     = 300;
    localparam int                 BACKLOG_CYCLES = 1500;
    localparam int                 DRAIN_CYCLES   = 400;
    localparam int                 WATCHDOG_LIMIT = 6000;
    localparam logic [FIELD_W-1:0] WORD_MAX       = {FIELD_W{1'b1}};
    localparam logic [FIELD_W-1:0] TOP_BIT        = {1'b1, {(FIELD_W-1){1'b0}}};

    typedef struct packed {
        logic        [FIELD_W-1:0] gcd;
        logic signed [FIELD_W-1:0] ucoef;
        logic signed [FIELD_W-1:0] vcoef;
    } bezout_t;

    typedef struct packed {
        logic [FIELD_W-1:0] first;
        logic [FIELD_W-1:0] second;
        logic               typed;
        bezout_t            want;
    } directed_row_t;

    localparam bezout_t NO_RESULT = '0;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bgcd_in_if  req_if ();
    bgcd_out_if rsp_if ();

    binary_extended_gcd_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    bezout_t pending_results [$];
    int      mismatches     = 0;
    int      operands_taken = 0;
    int      burst_left     = 0;
    int      idle_cycles    = 0;
    bit      backlog_done   = 1'b0;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{64'd0, 64'd0, 1'b1, '{64'd0, 64'sd0, 64'sd0}},
        '{64'd0, WORD_MAX, 1'b1, '{WORD_MAX, 64'sd0, 64'sd1}},
        '{WORD_MAX, 64'd0, 1'b1, '{WORD_MAX, 64'sd1, 64'sd0}},
        '{64'd0, 64'd1, 1'b1, '{64'd1, 64'sd0, 64'sd1}},
        '{64'd1, 64'd0, 1'b1, '{64'd1, 64'sd1, 64'sd0}},
        '{64'd1, 64'd1, 1'b1, '{64'd1, 64'sd0, 64'sd1}},
        '{WORD_MAX, WORD_MAX, 1'b1, '{WORD_MAX, 64'sd0, 64'sd1}},
        '{TOP_BIT, TOP_BIT, 1'b1, '{TOP_BIT, 64'sd0, 64'sd1}},
        '{64'd1, WORD_MAX, 1'b0, NO_RESULT},
        '{WORD_MAX, 64'd1, 1'b0, NO_RESULT},
        '{TOP_BIT, 64'd1, 1'b0, NO_RESULT},
        '{64'd1, TOP_BIT, 1'b0, NO_RESULT},
        '{TOP_BIT, 64'h4000_0000_0000_0000, 1'b0, NO_RESULT},
        '{WORD_MAX, WORD_MAX - 64'd1, 1'b0, NO_RESULT},
        '{WORD_MAX - 64'd1, WORD_MAX, 1'b0, NO_RESULT},
        '{64'd6, 64'd4, 1'b0, NO_RESULT},
        '{64'd240, 64'd46, 1'b0, NO_RESULT},
        '{TOP_BIT, WORD_MAX, 1'b0, NO_RESULT},
        '{64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, NO_RESULT},
        '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, NO_RESULT},
        '{64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FF43, 1'b0, NO_RESULT},
        '{64'd12, 64'd18, 1'b0, NO_RESULT},
        '{64'h0000_0001_0000_0000, 64'h0001_0001_0000_0000, 1'b0, NO_RESULT},
        '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0, NO_RESULT}
    };

    function automatic int trailing_zeros(input t_word w);
        int n;
        n = 0;
        while (n < OPERAND_WIDTH - 1 && !w[n])
            n++;
        return n;
    endfunction

    function automatic bezout_t predict_bezout(input logic [FIELD_W-1:0] first_in,
                                               input logic [FIELD_W-1:0] second_in);
        t_word   x, y, pv0, pu0, pv1, pu1, du, dv, hu, hv, odd_mask;
        int      common, acc, k, i;
        bezout_t r;
        x = first_in[OPERAND_WIDTH-1:0];
        y = second_in[OPERAND_WIDTH-1:0];
        if (x == '0) begin
            r.gcd   = FIELD_W'(y);
            r.ucoef = '0;
            r.vcoef = (y == '0) ? '0 : FIELD_W'(1);
            return r;
        end
        if (y == '0) begin
            r.gcd   = FIELD_W'(x);
            r.ucoef = FIELD_W'(1);
            r.vcoef = '0;
            return r;
        end
        pv0 = 1; pu0 = 0; pv1 = 0; pu1 = 1;
        common = trailing_zeros(x | y);
        x = x >> common;
        y = y >> common;
        acc = 0;
        if (!x[0]) begin
            acc = trailing_zeros(x);
            x   = x >> acc;
            pu1 = pu1 << acc;
        end else if (!y[0]) begin
            acc = trailing_zeros(y);
            y   = y >> acc;
            pv0 = pv0 << acc;
        end
        while (x != y) begin
            if (x > y) begin
                x   = x - y;
                k   = trailing_zeros(x);
                x   = x >> k;
                pu0 = pu0 + pu1; pu1 = pu1 << k;
                pv0 = pv0 + pv1; pv1 = pv1 << k;
            end else begin
                y   = y - x;
                k   = trailing_zeros(y);
                y   = y >> k;
                pu1 = pu1 + pu0; pu0 = pu0 << k;
                pv1 = pv1 + pv0; pv0 = pv0 << k;
            end
            acc += k;
        end
        du = pu0 + pu1;
        dv = pv0 + pv1;
        hu = (du >> 1) + t_word'(du[0]);
        hv = (dv >> 1) + t_word'(dv[0]);
        for (i = 0; i < acc; i++) begin
            odd_mask = {OPERAND_WIDTH{pv0[0] | pu0[0]}};
            pv0 = (pv0 >> 1) + (odd_mask & hv);
            pu0 = (pu0 >> 1) + (odd_mask & hu);
        end
        if (pv0 > t_word'(dv - pv0)) begin
            pv0 = pv0 - dv;
            pu0 = pu0 - du;
        end
        r.gcd   = FIELD_W'(t_word'(y << common));
        r.ucoef = FIELD_W'($signed(pv0));
        r.vcoef = FIELD_W'($signed(t_word'(-pu0)));
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [FIELD_W-1:0] narrow_word(input int bits);
        return random_word() >> (FIELD_W - bits);
    endfunction

    function automatic void draw_operands(output logic [FIELD_W-1:0] a,
                                          output logic [FIELD_W-1:0] b);
        logic [FIELD_W-1:0] g;
        int                 pick, k;
        pick = $urandom_range(0, 15);
        case (pick)
            6, 7: begin
                a = narrow_word($urandom_range(1, FIELD_W));
                b = narrow_word($urandom_range(1, FIELD_W));
            end
            8, 9: begin
                g = narrow_word($urandom_range(1, 24));
                a = g * narrow_word($urandom_range(1, 40));
                b = g * narrow_word($urandom_range(1, 40));
            end
            10: begin
                k = $urandom_range(1, FIELD_W - 1);
                a = random_word() << k;
                b = random_word() << k;
            end
            11: begin
                k = $urandom_range(0, 2);
                a = (k == 1) ? narrow_word($urandom_range(1, FIELD_W)) : '0;
                b = (k == 0) ? narrow_word($urandom_range(1, FIELD_W)) : '0;
            end
            12: begin
                a = narrow_word($urandom_range(1, FIELD_W));
                b = a;
            end
            13: begin
                a = random_word();
                b = $urandom_range(0, 1) ? a - $urandom_range(1, 16) : a + $urandom_range(1, 16);
            end
            14: begin
                a = FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
                b = random_word();
                if ($urandom_range(0, 1)) begin
                    g = a; a = b; b = g;
                end
            end
            15: begin
                a = $urandom_range(0, 1000);
                b = $urandom_range(0, 1000);
            end
            default: begin
                a = random_word();
                b = random_word();
            end
        endcase
    endfunction

    // hold the item until taken, then either go on with the burst or idle for a while
    task automatic present_operands(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b,
                                    input bezout_t want);
        int gap;
        req_if.valid          <= 1'b1;
        req_if.first_operand  <= a;
        req_if.second_operand <= b;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        pending_results.push_back(want);
        operands_taken++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            req_if.valid <= 1'b0;
            gap = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(9, 400);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin : stimulus
        logic [FIELD_W-1:0] a, b;
        req_if.valid          <= 1'b0;
        req_if.first_operand  <= '0;
        req_if.second_operand <= '0;
        i_rst_n               <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[r]) begin
            present_operands(directed_rows[r].first, directed_rows[r].second,
                             directed_rows[r].typed ? directed_rows[r].want
                             : predict_bezout(directed_rows[r].first, directed_rows[r].second));
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            draw_operands(a, b);
            present_operands(a, b, predict_bezout(a, b));
        end
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : receiver
        int mode, span;
        rsp_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(16, 400);
            repeat (span) begin
                @(posedge i_clk);
                // hold off long enough for the block to back up into its input
                if (!backlog_done && operands_taken >= BACKLOG_AT) begin
                    rsp_if.ready <= 1'b0;
                    repeat (BACKLOG_CYCLES) @(posedge i_clk);
                    backlog_done = 1'b1;
                end
                case (mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                    default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        bezout_t want;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result item with none expected: gcd_value %h", rsp_if.gcd_value);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.gcd_value !== want.gcd) begin
                    $error("gcd_value: expected %h, got %h", want.gcd, rsp_if.gcd_value);
                    mismatches++;
                end
                if (rsp_if.u_coefficient !== want.ucoef) begin
                    $error("u_coefficient: expected %0d, got %0d",
                           want.ucoef, rsp_if.u_coefficient);
                    mismatches++;
                end
                if (rsp_if.v_coefficient !== want.vcoef) begin
                    $error("v_coefficient: expected %0d, got %0d",
                           want.vcoef, rsp_if.v_coefficient);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((req_if.valid === 1'b1 && req_if.ready === 1'b1)
                    || (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
